>>> rtl/adsr_envelope_generator_core_defines.svh
// Assertion macros shared by the envelope generator RTL.
`ifndef ADSR_ENVELOPE_GENERATOR_CORE_DEFINES_SVH
`define ADSR_ENVELOPE_GENERATOR_CORE_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, checked on every rising edge outside reset.
`define ADSR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("envelope assertion failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define ADSR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("envelope assertion failed");
`else
`define ADSR_ASSERT_IMP(lbl, ante, cons)
`define ADSR_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> rtl/adsr_pkg.sv
// Shared widths, codes and types of the ADSR envelope generator.
package adsr_pkg;

  // Field and state widths.
  localparam int TIME_BITS       = 26;
  localparam int LEVEL_FRAC_BITS = 16;
  localparam int LEVEL_W         = LEVEL_FRAC_BITS + 1;
  localparam int DUR_W           = 23;
  localparam int DT_W            = 16;
  localparam int CMD_W           = 2;
  localparam int STAGE_W         = 3;

  // Multiply-divide unit sizes. The quotient can reach full scale, so it
  // carries the integer bit of a level too.
  localparam int PROD_W = LEVEL_W + TIME_BITS;
  localparam int QUOT_W = LEVEL_W;
  localparam int CNT_W  = $clog2(LEVEL_W);

  // Configuration port.
  localparam int NUM_REGS = 5;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = $clog2(NUM_REGS * 4);
  localparam int IDX_W    = ADDR_W - 2;

  localparam logic [IDX_W-1:0] REG_ATTACK   = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_DECAY    = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_SUSTAIN  = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_RELEASE  = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_REACTIVE = IDX_W'(4);

  // Level and time constants.
  localparam logic [LEVEL_W-1:0]   FULL_LEVEL      = LEVEL_W'(1) << LEVEL_FRAC_BITS;
  localparam logic [LEVEL_W-1:0]   HALF_LEVEL      = LEVEL_W'(1) << (LEVEL_FRAC_BITS - 1);
  localparam logic [DUR_W-1:0]     INSTANT_US      = DUR_W'(1000);
  localparam logic [TIME_BITS-1:0] AUTO_RELEASE_US = TIME_BITS'(2000000);
  localparam logic [TIME_BITS-1:0] TIME_MAX        = '1;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TRIGGER = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP     = 2'd3;

  // Envelope stage codes.
  localparam logic [STAGE_W-1:0] ST_IDLE    = 3'd0;
  localparam logic [STAGE_W-1:0] ST_ATTACK  = 3'd1;
  localparam logic [STAGE_W-1:0] ST_DECAY   = 3'd2;
  localparam logic [STAGE_W-1:0] ST_SUSTAIN = 3'd3;
  localparam logic [STAGE_W-1:0] ST_RELEASE = 3'd4;

  // Configuration register set.
  typedef struct packed {
    logic [DUR_W-1:0]   attack_us;
    logic [DUR_W-1:0]   decay_us;
    logic [LEVEL_W-1:0] sustain_level;
    logic [DUR_W-1:0]   release_us;
    logic               reactive_enable;
  } cfg_t;

  // Request to the multiply-divide unit: floor(mplier * mcand / divisor).
  typedef struct packed {
    logic                 start;
    logic [LEVEL_W-1:0]   mplier;
    logic [TIME_BITS-1:0] mcand;
    logic [DUR_W-1:0]     divisor;
  } muldiv_req_t;

  // Response of the multiply-divide unit.
  typedef struct packed {
    logic              busy;
    logic              done;
    logic [QUOT_W-1:0] quot;
  } muldiv_rsp_t;

endpackage

>>> rtl/adsr_in_if.sv
// Input item channel: command, elapsed time and audio level.
interface adsr_in_if;
  logic                            valid;
  logic                            ready;
  logic [adsr_pkg::CMD_W-1:0]      cmd;
  logic [adsr_pkg::DT_W-1:0]       dt_us;
  logic [adsr_pkg::LEVEL_W-1:0]    audio_level;

  modport source (output valid, cmd, dt_us, audio_level, input ready);
  modport sink (input valid, cmd, dt_us, audio_level, output ready);
endinterface

>>> rtl/adsr_out_if.sv
// Result item channel: envelope level and stage.
interface adsr_out_if;
  logic                         valid;
  logic                         ready;
  logic [adsr_pkg::LEVEL_W-1:0] level;
  logic [adsr_pkg::STAGE_W-1:0] stage;

  modport source (output valid, level, stage, input ready);
  modport sink (input valid, level, stage, output ready);
endinterface

>>> rtl/adsr_envelope_generator_core.sv
// Trigger, release or no-op: the item goes straight from S_WAIT to S_DONE.
// Tick with no ramp division: the item passes through S_PREP, S_EVAL and S_DONE.
// Tick in an attack, decay or release ramp: the item passes through S_PREP, S_EVAL, S_CALC
// and S_DONE; S_CALC waits on the serial multiply-divide unit (17 multiply steps, then 17
// divide steps). A result held by the sink stalls S_DONE and so delays the next accept.
// Reset (asynchronous, active low): stage idle, level zero, stage time zero, default config.
`include "adsr_envelope_generator_core_defines.svh"
module adsr_envelope_generator_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [adsr_pkg::ADDR_W-1:0] paddr,
  input  logic [adsr_pkg::DATA_W-1:0] pwdata,
  output logic [adsr_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  adsr_in_if.sink                     item_in,
  adsr_out_if.source                  item_out
);

  localparam int TB = adsr_pkg::TIME_BITS;
  localparam int LW = adsr_pkg::LEVEL_W;
  localparam int DW = adsr_pkg::DUR_W;
  localparam int SW = adsr_pkg::STAGE_W;

  localparam logic [2:0] S_WAIT = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_CALC = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  adsr_pkg::cfg_t        cfg;
  adsr_pkg::muldiv_req_t md_req;
  adsr_pkg::muldiv_rsp_t md_rsp;

  logic [2:0]                 state_q, state_d;
  logic [SW-1:0]              stage_q, stage_d;
  logic [TB-1:0]              el_q, el_d;
  logic [LW-1:0]              level_q, level_d;
  logic [LW-1:0]              lar_q, lar_d;
  logic [adsr_pkg::DT_W-1:0]  dt_q, dt_d;
  logic [LW-1:0]              audio_q, audio_d;
  logic                       out_valid_q, out_valid_d;
  logic [LW-1:0]              out_level_q, out_level_d;
  logic [SW-1:0]              out_stage_q, out_stage_d;

  logic [LW-1:0] sus_c;
  logic [TB-1:0] el_base;
  logic [TB:0]   el_sum;
  logic          auto_start;
  logic [DW-1:0] rel_left;

  adsr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  adsr_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

  // Sustain level clamped to full scale.
  assign sus_c = (cfg.sustain_level > adsr_pkg::FULL_LEVEL) ? adsr_pkg::FULL_LEVEL
                                                              : cfg.sustain_level;

  // Reactive auto-trigger and the saturating stage clock of a tick.
  assign auto_start = cfg.reactive_enable && (audio_q > adsr_pkg::HALF_LEVEL) &&
                      (stage_q == adsr_pkg::ST_IDLE);
  assign el_base    = auto_start ? '0 : el_q;
  assign el_sum     = {1'b0, el_base} + (TB + 1)'(dt_q);

  // Time left in release; only used while the stage time is below release_us.
  assign rel_left = cfg.release_us - el_q[DW-1:0];

  assign item_in.ready  = (state_q == S_WAIT);
  assign item_out.valid = out_valid_q;
  assign item_out.level = out_level_q;
  assign item_out.stage = out_stage_q;

  // Item sequencer and envelope update.
  always_comb begin
    state_d        = state_q;
    stage_d        = stage_q;
    el_d           = el_q;
    level_d        = level_q;
    lar_d          = lar_q;
    dt_d           = dt_q;
    audio_d        = audio_q;
    out_valid_d    = out_valid_q;
    out_level_d    = out_level_q;
    out_stage_d    = out_stage_q;
    md_req.start   = 1'b0;
    md_req.mplier  = adsr_pkg::FULL_LEVEL;
    md_req.mcand   = el_q;
    md_req.divisor = cfg.attack_us;

    if (out_valid_q && item_out.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_WAIT: begin
        if (item_in.valid) begin
          dt_d    = item_in.dt_us;
          audio_d = item_in.audio_level;
          state_d = S_DONE;
          unique case (item_in.cmd)
            adsr_pkg::CMD_TICK: state_d = S_PREP;
            adsr_pkg::CMD_TRIGGER: begin
              stage_d = adsr_pkg::ST_ATTACK;
              el_d    = '0;
            end
            adsr_pkg::CMD_RELEASE: begin
              if (stage_q != adsr_pkg::ST_IDLE) begin
                stage_d = adsr_pkg::ST_RELEASE;
                lar_d   = level_q;
                el_d    = '0;
              end
            end
            adsr_pkg::CMD_NOP: ;
            default: ;
          endcase
        end
      end
      S_PREP: begin
        if (auto_start) begin
          stage_d = adsr_pkg::ST_ATTACK;
        end
        el_d    = el_sum[TB] ? adsr_pkg::TIME_MAX : el_sum[TB-1:0];
        state_d = S_EVAL;
      end
      S_EVAL: begin
        state_d = S_DONE;
        unique case (stage_q)
          adsr_pkg::ST_ATTACK: begin
            if (cfg.attack_us <= adsr_pkg::INSTANT_US || el_q >= TB'(cfg.attack_us)) begin
              level_d = adsr_pkg::FULL_LEVEL;
              stage_d = adsr_pkg::ST_DECAY;
              el_d    = '0;
            end else begin
              md_req.start = 1'b1;
              state_d      = S_CALC;
            end
          end
          adsr_pkg::ST_DECAY: begin
            if (cfg.decay_us <= adsr_pkg::INSTANT_US || el_q >= TB'(cfg.decay_us)) begin
              level_d = sus_c;
              stage_d = adsr_pkg::ST_SUSTAIN;
              el_d    = '0;
            end else begin
              md_req.start   = 1'b1;
              md_req.mplier  = adsr_pkg::FULL_LEVEL - sus_c;
              md_req.divisor = cfg.decay_us;
              state_d        = S_CALC;
            end
          end
          adsr_pkg::ST_SUSTAIN: begin
            level_d = sus_c;
            if (cfg.reactive_enable && el_q > adsr_pkg::AUTO_RELEASE_US) begin
              stage_d = adsr_pkg::ST_RELEASE;
              lar_d   = sus_c;
              el_d    = '0;
            end
          end
          adsr_pkg::ST_RELEASE: begin
            if (cfg.release_us <= adsr_pkg::INSTANT_US ||
                el_q >= TB'(cfg.release_us)) begin
              level_d = '0;
              stage_d = adsr_pkg::ST_IDLE;
            end else begin
              md_req.start   = 1'b1;
              md_req.mplier  = lar_q;
              md_req.mcand   = TB'(rel_left);
              md_req.divisor = cfg.release_us;
              state_d        = S_CALC;
            end
          end
          default: begin
            level_d = '0;
            stage_d = adsr_pkg::ST_IDLE;
          end
        endcase
      end
      S_CALC: begin
        if (md_rsp.done) begin
          state_d = S_DONE;
          unique case (stage_q)
            adsr_pkg::ST_DECAY: level_d = adsr_pkg::FULL_LEVEL - LW'(md_rsp.quot);
            adsr_pkg::ST_RELEASE: begin
              level_d = LW'(md_rsp.quot);
              if (md_rsp.quot == '0) begin
                stage_d = adsr_pkg::ST_IDLE;
              end
            end
            default: level_d = LW'(md_rsp.quot);
          endcase
        end
      end
      S_DONE: begin
        // The output register takes the item once the previous one has left.
        if (!out_valid_q || item_out.ready) begin
          out_valid_d = 1'b1;
          out_level_d = level_q;
          out_stage_d = stage_q;
          state_d     = S_WAIT;
        end
      end
      default: state_d = S_WAIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_WAIT;
      stage_q     <= adsr_pkg::ST_IDLE;
      el_q        <= '0;
      level_q     <= '0;
      lar_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stage_q     <= stage_d;
      el_q        <= el_d;
      level_q     <= level_d;
      lar_q       <= lar_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dt_q        <= dt_d;
    audio_q     <= audio_d;
    out_level_q <= out_level_d;
    out_stage_q <= out_stage_d;
  end

  `ADSR_ASSERT_IMP(a_idle_level_zero, stage_q == adsr_pkg::ST_IDLE, level_q == '0)
  `ADSR_ASSERT_IMP(a_level_in_range, out_valid_q, out_level_q <= adsr_pkg::FULL_LEVEL)
  `ADSR_ASSERT_IMP(a_calc_blocks_input, state_q == S_CALC, !item_in.ready && md_rsp.busy || md_rsp.done)

endmodule

>>> rtl/adsr_regs.sv
// APB-style configuration registers of the envelope generator.
module adsr_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [adsr_pkg::ADDR_W-1:0]   paddr,
  input  logic [adsr_pkg::DATA_W-1:0]   pwdata,
  output logic [adsr_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output adsr_pkg::cfg_t                cfg_o
);

  adsr_pkg::cfg_t cfg_q, cfg_d;
  logic [adsr_pkg::IDX_W-1:0] idx;
  logic wr_en;

  assign idx    = paddr[adsr_pkg::ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Register write decode.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        adsr_pkg::REG_ATTACK:   cfg_d.attack_us       = pwdata[adsr_pkg::DUR_W-1:0];
        adsr_pkg::REG_DECAY:    cfg_d.decay_us        = pwdata[adsr_pkg::DUR_W-1:0];
        adsr_pkg::REG_SUSTAIN:  cfg_d.sustain_level   = pwdata[adsr_pkg::LEVEL_W-1:0];
        adsr_pkg::REG_RELEASE:  cfg_d.release_us      = pwdata[adsr_pkg::DUR_W-1:0];
        adsr_pkg::REG_REACTIVE: cfg_d.reactive_enable = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.attack_us       <= adsr_pkg::DUR_W'(100000);
      cfg_q.decay_us        <= adsr_pkg::DUR_W'(300000);
      cfg_q.sustain_level   <= adsr_pkg::LEVEL_W'(45875);
      cfg_q.release_us      <= adsr_pkg::DUR_W'(500000);
      cfg_q.reactive_enable <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back, zero-extended to the bus width.
  always_comb begin
    unique case (idx)
      adsr_pkg::REG_ATTACK:   prdata = adsr_pkg::DATA_W'(cfg_q.attack_us);
      adsr_pkg::REG_DECAY:    prdata = adsr_pkg::DATA_W'(cfg_q.decay_us);
      adsr_pkg::REG_SUSTAIN:  prdata = adsr_pkg::DATA_W'(cfg_q.sustain_level);
      adsr_pkg::REG_RELEASE:  prdata = adsr_pkg::DATA_W'(cfg_q.release_us);
      adsr_pkg::REG_REACTIVE: prdata = adsr_pkg::DATA_W'(cfg_q.reactive_enable);
      default:                prdata = '0;
    endcase
  end

endmodule

>>> rtl/adsr_muldiv.sv
// Bit-serial multiply followed by bit-serial restoring divide.
`include "adsr_envelope_generator_core_defines.svh"
module adsr_muldiv (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  adsr_pkg::muldiv_req_t req_i,
  output adsr_pkg::muldiv_rsp_t rsp_o
);

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_MUL  = 2'd1;
  localparam logic [1:0] M_DIV  = 2'd2;

  localparam int TB = adsr_pkg::TIME_BITS;
  localparam int LW = adsr_pkg::LEVEL_W;
  localparam int DW = adsr_pkg::DUR_W;
  localparam int QW = adsr_pkg::QUOT_W;
  localparam int CW = adsr_pkg::CNT_W;

  logic [1:0]                  mode_q, mode_d;
  logic [CW-1:0]               cnt_q, cnt_d;
  logic                        done_q, done_d;
  logic [adsr_pkg::PROD_W-1:0] p_q, p_d;
  logic [TB-1:0]               mcand_q, mcand_d;
  logic [DW-1:0]               div_q, div_d;
  logic [DW-1:0]               rem_q, rem_d;

  logic [TB:0] acc_sum;
  logic [DW:0] trial;
  logic [DW:0] trial_diff;
  logic        trial_ge;

  // One multiplier bit per cycle: add the multiplicand to the upper part, shift right.
  assign acc_sum = {1'b0, p_q[adsr_pkg::PROD_W-1:LW]} + (p_q[0] ? {1'b0, mcand_q} : '0);

  // One quotient bit per cycle: bring down the next numerator bit, try to subtract.
  assign trial      = {rem_q, p_q[QW-1]};
  assign trial_diff = trial - {1'b0, div_q};
  assign trial_ge   = (trial >= {1'b0, div_q});

  always_comb begin
    mode_d  = mode_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    p_d     = p_q;
    mcand_d = mcand_q;
    div_d   = div_q;
    rem_d   = rem_q;
    unique case (mode_q)
      M_IDLE: begin
        if (req_i.start) begin
          p_d     = {{TB{1'b0}}, req_i.mplier};
          mcand_d = req_i.mcand;
          div_d   = req_i.divisor;
          cnt_d   = '0;
          mode_d  = M_MUL;
        end
      end
      M_MUL: begin
        p_d = {acc_sum, p_q[LW-1:1]};
        if (cnt_q == CW'(LW - 1)) begin
          cnt_d  = '0;
          mode_d = M_DIV;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      M_DIV: begin
        // The first divide step starts from the product's upper bits as remainder.
        rem_d           = trial_ge ? trial_diff[DW-1:0] : trial[DW-1:0];
        p_d[QW-1:0]     = {p_q[QW-2:0], trial_ge};
        if (cnt_q == CW'(QW - 1)) begin
          mode_d = M_IDLE;
          done_d = 1'b1;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: mode_d = M_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // The remainder is loaded from the product at the switch to dividing.
  always_ff @(posedge clk_i) begin
    p_q     <= p_d;
    mcand_q <= mcand_d;
    div_q   <= div_d;
    if (mode_q == M_MUL && cnt_q == CW'(LW - 1)) begin
      rem_q <= p_d[DW+QW-1:QW];
    end else begin
      rem_q <= rem_d;
    end
  end

  assign rsp_o.busy = (mode_q != M_IDLE);
  assign rsp_o.done = done_q;
  assign rsp_o.quot = p_q[QW-1:0];

  `ADSR_ASSERT_IMP(a_rem_below_divisor, mode_q == M_DIV, rem_q < div_q)
  `ADSR_ASSERT_IMP(a_start_only_idle, req_i.start, mode_q == M_IDLE)
  `ADSR_ASSERT_NXT(a_done_single_pulse, done_q, !done_q && mode_q == M_IDLE)

endmodule
